[rtl/sfcc_pkg.sv]
// Shared types and conversion constants for the sensor frame checker.
`default_nettype none

package sfcc_pkg;

   // One received frame byte with its resync flag.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   // One converted frame result.
   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic [15:0]        temperature_word;
      logic [15:0]        humidity_word;
      logic               temperature_crc_bad;
      logic               humidity_crc_bad;
      logic               frame_status;
   } rsp_type;

   // A checked frame, queued between the byte front end and the converter.
   typedef struct packed {
      logic [15:0] temperature_word;
      logic [15:0] humidity_word;
      logic        temperature_bad;
      logic        humidity_bad;
   } frame_type;

   localparam int TEMP_PROD_W = 31;
   localparam int HUM_PROD_W  = 30;

   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [15:0] HALF_SCALE  = 16'd32767;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;

endpackage

`default_nettype wire

[rtl/sfcc_front.sv]
// Byte front end: frame position tracking, CRC-8 checks and word assembly.
`default_nettype none

module sfcc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sfcc_pkg::req_type req_data,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output sfcc_pkg::frame_type    push_data
);
   import sfcc_pkg::*;

   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Fold one byte into the CRC, MSB first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   logic [2:0]  pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] tword_ff, tword_in;
   logic        tbad_ff, tbad_in;
   logic        accept;
   logic [7:0]  b;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.rx_byte;

   always_comb begin
      pos_eff = (req_data.frame_start || pos_ff > POS_H_CRC) ? POS_T_HI : pos_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      tword_in = tword_ff;
      tbad_in  = tbad_ff;
      if (accept) begin
         unique case (pos_eff)
            POS_T_HI: begin
               crc_in  = crc8_step(CRC_INIT, b);
               high_in = b;
               pos_in  = POS_T_LO;
            end
            POS_T_LO: begin
               crc_in   = crc8_step(crc_ff, b);
               tword_in = {high_ff, b};
               pos_in   = POS_T_CRC;
            end
            POS_T_CRC: begin
               tbad_in = (b != crc_ff);
               crc_in  = CRC_INIT;
               pos_in  = POS_H_HI;
            end
            POS_H_HI: begin
               crc_in  = crc8_step(CRC_INIT, b);
               high_in = b;
               pos_in  = POS_H_LO;
            end
            POS_H_LO: begin
               crc_in = crc8_step(crc_ff, b);
               low_in = b;
               pos_in = POS_H_CRC;
            end
            POS_H_CRC: begin
               crc_in = CRC_INIT;
               pos_in = POS_T_HI;
            end
            default: begin
               pos_in = POS_T_HI;
            end
         endcase
      end
   end

   // Hand the finished frame to the queue on the humidity CRC byte.
   assign push_valid                = accept && (pos_eff == POS_H_CRC);
   assign push_data.temperature_word = tword_ff;
   assign push_data.humidity_word    = {high_ff, low_ff};
   assign push_data.temperature_bad  = tbad_ff;
   assign push_data.humidity_bad     = (b != crc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_T_HI;
         crc_ff   <= CRC_INIT;
         high_ff  <= '0;
         low_ff   <= '0;
         tword_ff <= '0;
         tbad_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         tword_ff <= tword_in;
         tbad_ff  <= tbad_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sfcc_queue.sv]
// Two-entry frame queue between the front end and the converter.
`default_nettype none

module sfcc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire sfcc_pkg::frame_type push_data,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output sfcc_pkg::frame_type      pop_data
);
   import sfcc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sfcc_back.sv]
// Converter: scale raw words to centi-units, divide by full scale, register result.
`default_nettype none

module sfcc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire sfcc_pkg::frame_type pop_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sfcc_pkg::rsp_type        rsp_data
);
   import sfcc_pkg::*;

   // Stage one: products with the rounding half added.
   logic                   s1_valid_ff, s1_valid_in;
   logic [TEMP_PROD_W-1:0] s1_tprod_ff;
   logic [HUM_PROD_W-1:0]  s1_hprod_ff;
   frame_type              s1_frame_ff;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic out_load, s1_load;

   // Stage two: divide by 65535 as x/65536 plus a one-step correction.
   logic [14:0] tq_hi, tq;
   logic [13:0] hq_hi, hq;
   logic [16:0] t_sum, h_sum;
   logic [15:0] t_signed;
   rsp_type     result;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign s1_load   = !s1_valid_ff || out_load;
   assign pop_ready = s1_load;

   always_comb begin
      s1_valid_in  = s1_load ? pop_valid : s1_valid_ff;
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

      tq_hi = s1_tprod_ff[TEMP_PROD_W-1:16];
      hq_hi = s1_hprod_ff[HUM_PROD_W-1:16];
      t_sum = {2'b00, tq_hi} + {1'b0, s1_tprod_ff[15:0]};
      h_sum = {3'b000, hq_hi} + {1'b0, s1_hprod_ff[15:0]};
      tq    = tq_hi + 15'(t_sum >= FULL_SCALE);
      hq    = hq_hi + 14'(h_sum >= FULL_SCALE);
      t_signed = {1'b0, tq} - TEMP_OFFSET;

      result.temperature_centi   = t_signed[14:0];
      result.humidity_centi      = hq;
      result.temperature_word    = s1_frame_ff.temperature_word;
      result.humidity_word       = s1_frame_ff.humidity_word;
      result.temperature_crc_bad = s1_frame_ff.temperature_bad;
      result.humidity_crc_bad    = s1_frame_ff.humidity_bad;
      result.frame_status        = s1_frame_ff.temperature_bad | s1_frame_ff.humidity_bad;
   end

   always_ff @(posedge clock) begin
      if (pop_valid && s1_load) begin
         s1_tprod_ff <= TEMP_PROD_W'(TEMP_SPAN) * TEMP_PROD_W'(pop_data.temperature_word)
                        + TEMP_PROD_W'(HALF_SCALE);
         s1_hprod_ff <= HUM_PROD_W'(HUM_SPAN) * HUM_PROD_W'(pop_data.humidity_word)
                        + HUM_PROD_W'(HALF_SCALE);
         s1_frame_ff <= pop_data;
      end
      if (s1_valid_ff && out_load) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[rtl/sensor_frame_crc_convert.sv]
// Top level of the temperature/humidity frame checker and converter.
//
// Usage:
//   req_ channel: one frame byte per word, in bus order: temperature high,
//   temperature low, temperature CRC, humidity high, humidity low, humidity
//   CRC. Set frame_start to force a byte to frame position zero; a partial
//   frame is then dropped. Frames may follow each other without frame_start.
//   rsp_ channel: one word per frame, after its sixth byte, with the raw
//   words, the converted centi-unit values and the CRC-8 (poly 0x31, init
//   0xFF) failure flags. A failed CRC still yields converted values.
// Timing:
//   One byte per cycle sustained while req_ready is high. The front end
//   hands the frame to the queue on the edge that takes the sixth byte;
//   the result then passes the queue, the multiply stage register and the
//   output register, fed by the divide/correct stage, to rsp_valid.
//   The multiply stage sets the cycle time.
// Reset:
//   reset (synchronous, active high) returns the byte position to zero,
//   loads the CRC with 0xFF and empties the queue and pipeline.
// Stall:
//   While rsp_ready is low the output word holds. The two-entry frame queue
//   and the pipeline stages keep absorbing frames; req_ready drops only when
//   the queue is full.
`default_nettype none

module sensor_frame_crc_convert (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sfcc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sfcc_pkg::rsp_type      rsp_data
);
   import sfcc_pkg::*;

   // Front end to queue.
   logic      push_valid, push_ready;
   frame_type push_data;

   // Queue to converter.
   logic      pop_valid, pop_ready;
   frame_type pop_data;

   // Track position, check CRCs, assemble words.
   sfcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple byte intake from conversion.
   sfcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Scale, divide and register the result word.
   sfcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/sfcc_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module sfcc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire sfcc_pkg::rsp_type rsp_data
);
   import sfcc_pkg::*;

   // Hold a stalled result word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Fault status tracks the two CRC flags.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frame_status ==
                    (rsp_data.temperature_crc_bad | rsp_data.humidity_crc_bad))
      else $error("frame_status disagrees with CRC flags");

   // Converted humidity stays within full scale.
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_centi <= 14'd10000)
      else $error("humidity out of range");

   // Converted temperature stays within sensor range.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.temperature_centi >= -15'sd4500) &&
                    (rsp_data.temperature_centi <= 15'sd13000))
      else $error("temperature out of range");

   // Drop any result on reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sensor_frame_crc_convert sfcc_checker u_sfcc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/tb_sensor_frame_crc_convert.sv]
// Self-checking testbench for the temperature/humidity frame checker and converter.
`timescale 1ns / 1ps

module tb_sensor_frame_crc_convert;
   import sfcc_pkg::*;

   // CRC-8 as the sensor computes it: poly 0x31, seed 0xFF, MSB first.
   localparam logic [7:0] CRC_SEED = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Scaling of the raw words into hundredths.
   localparam int TEMP_SPAN_CENTI   = 17500;
   localparam int TEMP_OFFSET_CENTI = 4500;
   localparam int HUM_SPAN_CENTI    = 10000;
   localparam int RAW_FULL_SCALE    = 65535;

   // Frame positions of the six bytes.
   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;

   // Advance the running CRC by one byte.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++)
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Tracks the frame byte by byte and holds the results still owed by the block.
   class frame_ledger;
      rsp_type     pending_frames[$];
      int unsigned failures;
      logic [2:0]  byte_pos;
      logic [7:0]  crc_acc;
      logic [7:0]  high_byte;
      logic [7:0]  low_byte;
      logic [15:0] temp_word;
      logic        temp_bad;

      function new();
         byte_pos  = POS_T_HI;
         crc_acc   = CRC_SEED;
         high_byte = '0;
         low_byte  = '0;
         temp_word = '0;
         temp_bad  = 1'b0;
         failures  = 0;
      endfunction

      function void take_byte(req_type w);
         logic [2:0]  pos;
         logic [15:0] hum_word;
         logic        hum_bad;
         int          tq;
         int          hq;
         rsp_type     r;
         pos = (w.frame_start || byte_pos > POS_H_CRC) ? POS_T_HI : byte_pos;
         case (pos)
            POS_T_HI, POS_H_HI: begin
               crc_acc   = crc8_step(CRC_SEED, w.rx_byte);
               high_byte = w.rx_byte;
               byte_pos  = pos + 3'd1;
            end
            POS_T_LO: begin
               crc_acc   = crc8_step(crc_acc, w.rx_byte);
               temp_word = {high_byte, w.rx_byte};
               byte_pos  = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_bad = (w.rx_byte != crc_acc);
               crc_acc  = CRC_SEED;
               byte_pos = POS_H_HI;
            end
            POS_H_LO: begin
               crc_acc  = crc8_step(crc_acc, w.rx_byte);
               low_byte = w.rx_byte;
               byte_pos = POS_H_CRC;
            end
            default: begin
               hum_bad  = (w.rx_byte != crc_acc);
               hum_word = {high_byte, low_byte};
               tq = (TEMP_SPAN_CENTI * int'(temp_word) + RAW_FULL_SCALE / 2) / RAW_FULL_SCALE;
               hq = (HUM_SPAN_CENTI * int'(hum_word) + RAW_FULL_SCALE / 2) / RAW_FULL_SCALE;
               r.temperature_centi   = 15'(tq - TEMP_OFFSET_CENTI);
               r.humidity_centi      = 14'(hq);
               r.temperature_word    = temp_word;
               r.humidity_word       = hum_word;
               r.temperature_crc_bad = temp_bad;
               r.humidity_crc_bad    = hum_bad;
               r.frame_status        = temp_bad | hum_bad;
               pending_frames.push_back(r);
               crc_acc  = CRC_SEED;
               byte_pos = POS_T_HI;
            end
         endcase
      endfunction

      function void check_field(string field, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
            failures++;
         end
      endfunction

      function void match_frame(rsp_type got);
         rsp_type want;
         if (pending_frames.size() == 0) begin
            $display("%0t: result with no frame pending, expected none, got %p", $time, got);
            failures++;
            return;
         end
         want = pending_frames.pop_front();
         check_field("temperature_centi", want.temperature_centi, got.temperature_centi);
         check_field("humidity_centi", want.humidity_centi, got.humidity_centi);
         check_field("temperature_word", want.temperature_word, got.temperature_word);
         check_field("humidity_word", want.humidity_word, got.humidity_word);
         check_field("temperature_crc_bad", want.temperature_crc_bad, got.temperature_crc_bad);
         check_field("humidity_crc_bad", want.humidity_crc_bad, got.humidity_crc_bad);
         check_field("frame_status", want.frame_status, got.frame_status);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   frame_ledger ledger = new();

   int unsigned send_idle_pct = 0;
   int unsigned rcv_idle_pct  = 0;
   int unsigned bytes_taken   = 0;
   int unsigned cycle_count   = 0;
   bit          hold_request  = 1'b0;
   bit          resync_next   = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sensor_frame_crc_convert i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Offer one byte; idle first at the current rate, then hold valid and the
   // payload until the word is taken.
   task automatic send_byte(input req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      ledger.take_byte(w);
      bytes_taken++;
   endtask

   // Send a full six-byte frame; corrupt a CRC byte with a nonzero xor on request.
   task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input logic t_bad, input logic h_bad, input logic resync);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = crc8_step(crc8_step(CRC_SEED, t_word[15:8]), t_word[7:0]);
      h_crc = crc8_step(crc8_step(CRC_SEED, h_word[15:8]), h_word[7:0]);
      if (t_bad)
         t_crc ^= 8'($urandom_range(1, 255));
      if (h_bad)
         h_crc ^= 8'($urandom_range(1, 255));
      send_byte({t_word[15:8], resync});
      send_byte({t_word[7:0], 1'b0});
      send_byte({t_crc, 1'b0});
      send_byte({h_word[15:8], 1'b0});
      send_byte({h_word[7:0], 1'b0});
      send_byte({h_crc, 1'b0});
   endtask

   // Favor the ends of the raw range now and then.
   function automatic logic [15:0] pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return 16'h0000;
      if (sel == 1)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Mostly well-formed frames, some cut short, some plain line noise.
   task automatic send_random_frame();
      int   mode;
      int   n;
      logic fs;
      mode = $urandom_range(0, 99);
      if (mode < 82) begin
         fs = resync_next || ($urandom_range(0, 1) == 1);
         resync_next = 1'b0;
         send_frame(pick_word(), pick_word(), $urandom_range(0, 99) < 18,
                    $urandom_range(0, 99) < 18, fs);
      end else if (mode < 92) begin
         // Drop a partial frame; the next one resyncs with frame_start.
         n = $urandom_range(1, 5);
         for (int k = 0; k < n; k++)
            send_byte({8'($urandom), (k == 0) ? 1'($urandom) : 1'b0});
         resync_next = 1'b1;
      end else begin
         n = $urandom_range(1, 8);
         for (int k = 0; k < n; k++)
            send_byte({8'($urandom), $urandom_range(0, 3) == 0});
         resync_next = 1'b1;
      end
   endtask

   // Drop valid and hold the sender until every owed result is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending_frames.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: check each accepted word against the oldest owed result, then
   // pick ready for the next cycle. A hold-off request keeps ready low for a
   // long stretch so the queue fills and req_ready drops.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            ledger.match_frame(rsp_data);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // Stop a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender sparse idling, receiver heavy idling.
      send_idle_pct = 16;
      rcv_idle_pct  = 53;

      // Directed: raw extremes, back-to-back frames without frame_start, a
      // partial frame dropped by frame_start, and each CRC failing alone.
      send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
      send_byte({8'hA5, 1'b1});
      send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1);
      send_frame(16'h1234, 16'hABCD, 1'b0, 1'b1, 1'b0);

      while (bytes_taken < 375)
         send_random_frame();
      wait_drained();

      // Swap the idling: sender heavy, receiver sparse.
      send_idle_pct = 53;
      rcv_idle_pct  = 16;
      while (bytes_taken < 725)
         send_random_frame();
      wait_drained();

      // No idling. Hold the receiver off while the sender keeps offering
      // frames to back the block up, then drain before going on.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      hold_request  = 1'b1;
      for (int k = 0; k < 10; k++)
         send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1);
      resync_next = 1'b0;
      wait_drained();

      while (bytes_taken < 1075)
         send_random_frame();
      wait_drained();
      repeat (16) @(posedge clock);

      if (ledger.pending_frames.size() != 0) begin
         $display("%0t: results never arrived, expected %0d more, got 0", $time,
                  ledger.pending_frames.size());
         ledger.failures++;
      end
      if (ledger.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
